// File: sv/bds_pkg.sv
`timescale 1ns / 1ps

package bds_pkg;

    // Field widths
    localparam int unsigned CLK_W    = 32;
    localparam int unsigned BAUD_W   = 20;
    localparam int unsigned DIVSR_W  = 8;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned CFG_IDX_W = 4;
    localparam int unsigned DIV_CNT_W = $clog2(CLK_W);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_INPUT_CLOCK_HZ = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_DIV8     = 4'd1;

    // Reset values of the configuration registers
    localparam logic [CLK_W-1:0] INPUT_CLOCK_HZ_RST = 32'd100000000;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_ERROR = 2'd2;

    // Search limits
    localparam logic [BAUD_W-1:0]  BAUD_MAX  = 20'd921600;
    localparam logic [BAUD_W-1:0]  BAUD_MIN  = 20'd110;
    localparam logic [DIVSR_W-1:0] DIV_FIRST = 8'd4;
    localparam logic [DIVSR_W-1:0] DIV_LAST  = 8'd254;
    localparam int unsigned        PRESCALE_SHIFT = 3;

    // Percentage check: floor(err * 100 / target) > 3  <=>  err * 100 >= 4 * target
    localparam int unsigned PCT_W      = CLK_W + 7;
    localparam logic [PCT_W-1:0] PCT_SCALE = 39'd100;
    localparam logic [PCT_W-1:0] PCT_LIMIT = 39'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_MUL_GEN,
        ST_DIV_GEN,
        ST_MUL_ACH,
        ST_DIV_ACH,
        ST_COMPARE,
        ST_DONE
    } bds_state_t;

endpackage

// File: sv/baud_divisor_search_core.sv
`timescale 1ns / 1ps

// UART baud divisor search. Each transaction on the s_ channel carries a
// requested baud rate; the core answers with one transaction on the m_
// channel giving the status, the baud generator count, the divisor (4..254)
// and the absolute rate error of the best pair found. Requests below 110 or
// above 921600, or whose double exceeds input_clock_hz, pass from setup
// straight to the done state and return status 1. Otherwise the core walks
// all 251 divisors through a single restoring divider that retires one
// quotient bit per cycle: each divisor takes a multiply step and a division
// for the generator count, the same again for the achieved rate, and a
// compare step. Divisors whose generator count comes out zero skip the
// second division and the compare. s_ready is high only while the core is
// idle; a finished result sits in the output register, so the next request
// can be taken while the previous result still waits on m_ready. Configuration
// writes (cfg index 0: input_clock_hz, index 1: clock_div8) are always
// accepted and must only be issued while no search is running.
module baud_divisor_search_core (
    input  logic                            aclk,
    input  logic                            aresetn,

    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [bds_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bds_pkg::CLK_W-1:0]       cfg_data,

    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [bds_pkg::BAUD_W-1:0]      s_target_baud,

    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [bds_pkg::STATUS_W-1:0]    m_status,
    output logic [bds_pkg::CLK_W-1:0]       m_generator_count,
    output logic [bds_pkg::DIVSR_W-1:0]     m_divisor,
    output logic [bds_pkg::CLK_W-1:0]       m_rate_error
);

    localparam logic [bds_pkg::DIV_CNT_W-1:0] DIV_CNT_LAST =
        bds_pkg::DIV_CNT_W'(bds_pkg::CLK_W - 1);

    // Configuration registers
    logic [bds_pkg::CLK_W-1:0]      clk_hz_reg;
    logic                           div8_reg;

    // Sequencer
    bds_pkg::bds_state_t            state_reg, state_next;

    // Working registers for one search
    logic [bds_pkg::BAUD_W-1:0]     target_reg;
    logic [bds_pkg::CLK_W-1:0]      ref_clk_reg;
    logic [bds_pkg::DIVSR_W-1:0]    d_reg;
    logic                           reject_reg;
    logic                           found_reg;
    logic [bds_pkg::CLK_W-1:0]      gen_reg;
    logic [bds_pkg::CLK_W-1:0]      best_err_reg;
    logic [bds_pkg::CLK_W-1:0]      best_gen_reg;
    logic [bds_pkg::DIVSR_W-1:0]    best_div_reg;

    // Shared divider: quotient shifts in while the dividend shifts out
    logic [bds_pkg::CLK_W-1:0]      den_reg;
    logic [bds_pkg::CLK_W-1:0]      rem_reg;
    logic [bds_pkg::CLK_W-1:0]      quo_reg;
    logic [bds_pkg::DIV_CNT_W-1:0]  div_cnt_reg;

    // Output register
    logic                           m_valid_reg;
    logic [bds_pkg::STATUS_W-1:0]   m_status_reg;
    logic [bds_pkg::CLK_W-1:0]      m_gen_reg;
    logic [bds_pkg::DIVSR_W-1:0]    m_div_reg;
    logic [bds_pkg::CLK_W-1:0]      m_err_reg;

    // Control decoded from the state
    logic                           div_load;
    logic                           div_step;
    logic                           capture_gen;
    logic                           update_cand;
    logic                           advance_d;
    logic                           load_result;

    logic                           reject_now;
    logic                           div_last;
    logic                           d_last;
    logic                           gen_zero;
    logic [bds_pkg::DIVSR_W-1:0]    mult_m;
    logic [bds_pkg::CLK_W-1:0]      mul_a;
    logic [bds_pkg::CLK_W+bds_pkg::DIVSR_W-1:0] mul_prod;
    logic [bds_pkg::CLK_W:0]        div_shift;
    logic                           div_fits;
    logic [bds_pkg::CLK_W:0]        div_diff;
    logic [bds_pkg::CLK_W-1:0]      target_ext;
    logic [bds_pkg::CLK_W-1:0]      cand_err;
    logic                           cand_better;
    logic [bds_pkg::PCT_W-1:0]      pct_lhs;
    logic [bds_pkg::PCT_W-1:0]      pct_rhs;
    logic                           pct_over;
    logic [bds_pkg::STATUS_W-1:0]   res_status;
    logic [bds_pkg::CLK_W-1:0]      res_gen;
    logic [bds_pkg::DIVSR_W-1:0]    res_div;
    logic [bds_pkg::CLK_W-1:0]      res_err;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == bds_pkg::ST_IDLE);

    // Range and too-fast checks use the undivided clock
    assign reject_now = (target_reg > bds_pkg::BAUD_MAX) || (target_reg < bds_pkg::BAUD_MIN) ||
                        (bds_pkg::CLK_W'({target_reg, 1'b0}) > clk_hz_reg);

    assign div_last = (div_cnt_reg == DIV_CNT_LAST);
    assign d_last   = (d_reg == bds_pkg::DIV_LAST);
    assign gen_zero = (quo_reg == '0);

    // Single multiplier: target * (d + 1) for the generator divide, then
    // gen * (d + 1) for the achieved-rate divide. gen * (d + 1) never exceeds
    // the clock, so the low 32 bits are exact in both uses.
    assign mult_m   = d_reg + 8'd1;
    assign mul_a    = (state_reg == bds_pkg::ST_MUL_ACH) ? quo_reg
                                                         : bds_pkg::CLK_W'(target_reg);
    assign mul_prod = mul_a * mult_m;

    // One restoring step: remainder stays below den, so the difference fits
    assign div_shift = {rem_reg, quo_reg[bds_pkg::CLK_W-1]};
    assign div_fits  = (div_shift >= {1'b0, den_reg});
    assign div_diff  = div_shift - {1'b0, den_reg};

    // Candidate error against the achieved rate left in the quotient
    assign target_ext  = bds_pkg::CLK_W'(target_reg);
    assign cand_err    = (quo_reg > target_ext) ? (quo_reg - target_ext)
                                                : (target_ext - quo_reg);
    assign cand_better = !found_reg || (cand_err < best_err_reg);

    // Percentage test without a divide
    assign pct_lhs  = bds_pkg::PCT_W'(best_err_reg) * bds_pkg::PCT_SCALE;
    assign pct_rhs  = bds_pkg::PCT_W'(target_reg) * bds_pkg::PCT_LIMIT;
    assign pct_over = (pct_lhs >= pct_rhs);

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            bds_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = bds_pkg::ST_SETUP;
                end
            end
            bds_pkg::ST_SETUP: begin
                state_next = reject_now ? bds_pkg::ST_DONE : bds_pkg::ST_MUL_GEN;
            end
            bds_pkg::ST_MUL_GEN: begin
                state_next = bds_pkg::ST_DIV_GEN;
            end
            bds_pkg::ST_DIV_GEN: begin
                if (div_last) begin
                    state_next = bds_pkg::ST_MUL_ACH;
                end
            end
            bds_pkg::ST_MUL_ACH: begin
                if (!gen_zero) begin
                    state_next = bds_pkg::ST_DIV_ACH;
                end else if (d_last) begin
                    state_next = bds_pkg::ST_DONE;
                end else begin
                    state_next = bds_pkg::ST_MUL_GEN;
                end
            end
            bds_pkg::ST_DIV_ACH: begin
                if (div_last) begin
                    state_next = bds_pkg::ST_COMPARE;
                end
            end
            bds_pkg::ST_COMPARE: begin
                state_next = d_last ? bds_pkg::ST_DONE : bds_pkg::ST_MUL_GEN;
            end
            bds_pkg::ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = bds_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = bds_pkg::ST_IDLE;
            end
        endcase
    end

    // Control outputs
    always_comb begin
        div_load    = 1'b0;
        div_step    = 1'b0;
        capture_gen = 1'b0;
        update_cand = 1'b0;
        advance_d   = 1'b0;
        load_result = 1'b0;
        case (state_reg)
            bds_pkg::ST_MUL_GEN: begin
                div_load = 1'b1;
            end
            bds_pkg::ST_DIV_GEN: begin
                div_step = 1'b1;
            end
            bds_pkg::ST_MUL_ACH: begin
                capture_gen = 1'b1;
                div_load    = !gen_zero;
                advance_d   = gen_zero;
            end
            bds_pkg::ST_DIV_ACH: begin
                div_step = 1'b1;
            end
            bds_pkg::ST_COMPARE: begin
                update_cand = cand_better;
                advance_d   = 1'b1;
            end
            bds_pkg::ST_DONE: begin
                load_result = !m_valid_reg || m_ready;
            end
            default: begin
            end
        endcase
    end

    // Result selection
    always_comb begin
        res_status = bds_pkg::STATUS_OK;
        res_gen    = best_gen_reg;
        res_div    = best_div_reg;
        res_err    = best_err_reg;
        if (reject_reg) begin
            res_status = bds_pkg::STATUS_RANGE;
            res_gen    = '0;
            res_div    = '0;
            res_err    = '0;
        end else if (!found_reg) begin
            res_status = bds_pkg::STATUS_ERROR;
            res_gen    = '0;
            res_div    = '0;
            res_err    = '0;
        end else if (pct_over) begin
            res_status = bds_pkg::STATUS_ERROR;
            res_gen    = '0;
            res_div    = '0;
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= bds_pkg::ST_IDLE;
            clk_hz_reg  <= bds_pkg::INPUT_CLOCK_HZ_RST;
            div8_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    bds_pkg::CFG_INPUT_CLOCK_HZ: clk_hz_reg <= cfg_data;
                    bds_pkg::CFG_CLOCK_DIV8:     div8_reg   <= cfg_data[0];
                    default: begin
                        // drop writes to unmapped indexes
                    end
                endcase
            end
            if (load_result) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            target_reg <= s_target_baud;
        end

        if (state_reg == bds_pkg::ST_SETUP) begin
            // Start a new search from the first divisor
            reject_reg   <= reject_now;
            ref_clk_reg  <= div8_reg ? (clk_hz_reg >> bds_pkg::PRESCALE_SHIFT) : clk_hz_reg;
            d_reg        <= bds_pkg::DIV_FIRST;
            found_reg    <= 1'b0;
            best_err_reg <= '0;
            best_gen_reg <= '0;
            best_div_reg <= '0;
        end

        if (div_load) begin
            den_reg     <= mul_prod[bds_pkg::CLK_W-1:0];
            rem_reg     <= '0;
            quo_reg     <= ref_clk_reg;
            div_cnt_reg <= '0;
        end else if (div_step) begin
            rem_reg     <= div_fits ? div_diff[bds_pkg::CLK_W-1:0]
                                    : div_shift[bds_pkg::CLK_W-1:0];
            quo_reg     <= {quo_reg[bds_pkg::CLK_W-2:0], div_fits};
            div_cnt_reg <= div_cnt_reg + 1'b1;
        end

        if (capture_gen) begin
            gen_reg <= quo_reg;
        end

        if (update_cand) begin
            found_reg    <= 1'b1;
            best_err_reg <= cand_err;
            best_gen_reg <= gen_reg;
            best_div_reg <= d_reg;
        end

        if (advance_d) begin
            d_reg <= d_reg + 8'd1;
        end

        if (load_result) begin
            m_status_reg <= res_status;
            m_gen_reg    <= res_gen;
            m_div_reg    <= res_div;
            m_err_reg    <= res_err;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_status          = m_status_reg;
    assign m_generator_count = m_gen_reg;
    assign m_divisor         = m_div_reg;
    assign m_rate_error      = m_err_reg;

    // An accepted request always starts the setup step
    a_accept_setup: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == bds_pkg::ST_SETUP))
        else $error("accepted request did not enter setup");

    // A new result only appears out of the publish step
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == bds_pkg::ST_DONE))
        else $error("result raised outside publish step");

    // The divider never runs against a zero denominator
    a_den_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        div_step |-> (den_reg != '0))
        else $error("divider stepping with zero denominator");

    // Each division starts from a cleared step count
    a_div_start: assert property (@(posedge aclk) disable iff (!aresetn)
        div_load |=> (div_cnt_reg == '0) && (rem_reg == '0))
        else $error("divider not initialized on load");

    // An accepted pair has a legal divisor and a nonzero generator count
    a_ok_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_status_reg == bds_pkg::STATUS_OK)) |->
        (m_div_reg >= bds_pkg::DIV_FIRST) && (m_div_reg <= bds_pkg::DIV_LAST) &&
        (m_gen_reg != '0))
        else $error("ok result with illegal divisor or zero generator");

    // A failed search reports no pair
    a_fail_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_status_reg != bds_pkg::STATUS_OK)) |->
        (m_div_reg == '0) && (m_gen_reg == '0))
        else $error("failed result carries a divisor pair");

endmodule
